[rtl/lpdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lpdt_pkg;

  localparam int POS_W    = 48;
  localparam int COORD_W  = 16;
  localparam int RAD_W    = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int DOT_W    = SQ_W + 2;
  localparam int RSUM_W   = RAD_W + 1;
  localparam int RSQ_W    = 2 * RSUM_W;
  localparam int PROD_W   = 2 * DOT_W;
  localparam int T_W      = 24;
  localparam int T_FRAC   = 16;
  localparam int QB       = T_W + 1;
  localparam int DIV1_DW  = PROD_W;
  localparam int DIV2_DW  = DOT_W;
  localparam int TB_W     = T_W + DOT_W;
  localparam int NUM2_W   = TB_W + 2;
  localparam int P_W      = T_W + DIFF_W;
  localparam int W_W      = P_W + 3;
  localparam int WMAG_W   = W_W - 1;
  localparam int WLO_W    = 22;
  localparam int WHI_W    = WMAG_W - WLO_W;
  localparam int DIST_W   = 2 * WMAG_W + 2;
  localparam int DQ_W     = 40;
  localparam int DQ_SHIFT = 32;

  localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic [QB-1:0]  T_LIM = QB'(1) << (T_W - 1);

  typedef logic [2:0][DIFF_W-1:0] vec_t;

  typedef struct packed {
    vec_t             d1;
    vec_t             d2;
    vec_t             r;
    logic [DOT_W-1:0] b;
    logic [DOT_W-1:0] f;
    logic [DOT_W-1:0] e;
    logic [RSQ_W-1:0] rsq;
    logic             degen;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic neg;
    logic ovf;
  } d1tag_t;

  typedef struct packed {
    ctx_t           ctx;
    logic [T_W-1:0] t1;
    logic           neg;
    logic           ovf;
  } d2tag_t;

  function automatic logic [T_W-1:0] clamp_t(input logic neg, input logic ovf,
                                             input logic [QB-1:0] q);
    logic [QB-1:0] nq;
    nq = -q;
    if (ovf) begin
      return neg ? T_MIN : T_MAX;
    end else if (neg) begin
      return (q > T_LIM) ? T_MIN : nq[T_W-1:0];
    end else begin
      return (q >= T_LIM) ? T_MAX : q[T_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/lpdt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lpdt_in_if;
  logic                       valid;
  logic                       ready;
  logic [lpdt_pkg::POS_W-1:0] first_start;
  logic [lpdt_pkg::POS_W-1:0] first_end;
  logic [lpdt_pkg::RAD_W-1:0] first_radius;
  logic [lpdt_pkg::POS_W-1:0] second_start;
  logic [lpdt_pkg::POS_W-1:0] second_end;
  logic [lpdt_pkg::RAD_W-1:0] second_radius;

  modport source (output valid, first_start, first_end, first_radius,
                  second_start, second_end, second_radius, input ready);
  modport sink (input valid, first_start, first_end, first_radius,
                second_start, second_end, second_radius, output ready);
endinterface

interface lpdt_out_if;
  logic                      valid;
  logic                      ready;
  logic                      collided;
  logic [lpdt_pkg::DQ_W-1:0] dist_squared;
  logic                      degenerate;

  modport source (output valid, collided, dist_squared, degenerate, input ready);
  modport sink (input valid, collided, dist_squared, degenerate, output ready);
endinterface

`default_nettype wire

[rtl/lpdt_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module lpdt_div #(
  parameter int DW = 72,
  parameter int QB = 25,
  parameter int TW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DW+QB-1:0] in_num,
  input  logic [DW-1:0]    in_den,
  input  logic [TW-1:0]    in_tag,
  output logic             out_valid,
  output logic [QB-1:0]    out_quo,
  output logic [TW-1:0]    out_tag
);

  localparam int RW = DW + QB;

  logic [RW-1:0] rem_r [1:QB];
  logic [DW-1:0] den_r [1:QB];
  logic [QB-1:0] quo_r [1:QB];
  logic [TW-1:0] tag_r [1:QB];
  logic          vld_r [1:QB];

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int B = QB - 1 - i;
    logic [RW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [RW-1:0] dsh;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign tag_in = in_tag;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[i];
      assign den_in = den_r[i];
      assign quo_in = quo_r[i];
      assign tag_in = tag_r[i];
      assign vld_in = vld_r[i];
    end

    assign dsh = RW'(den_in) << B;
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? rem_in - dsh : rem_in;
        den_r[i+1] <= den_in;
        quo_r[i+1] <= {quo_in[QB-2:0], ge};
        tag_r[i+1] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[QB];
  assign out_quo   = quo_r[QB];
  assign out_tag   = tag_r[QB];

endmodule

`default_nettype wire

[rtl/line_pair_distance_test.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake     Word
// in_chan   in         valid/ready   two capsules: start, end, radius each
// out_chan  out        valid/ready   collided, dist_squared, degenerate
//
// One word enters per cycle unless the output is stalled.
// t1 and t2 come from two 25-stage restoring dividers, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears every valid bit; data registers hold.
// A stalled output freezes the whole pipeline, and in_chan.ready drops with it.

module line_pair_distance_test (
  input  logic       clk,
  input  logic       rst_n,
  lpdt_in_if.sink    in_chan,
  lpdt_out_if.source out_chan
);

  localparam int RW1 = lpdt_pkg::DIV1_DW + lpdt_pkg::QB;
  localparam int RW2 = lpdt_pkg::DIV2_DW + lpdt_pkg::QB;

  logic en;
  logic out_vld_r;

  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 1: differences
  lpdt_pkg::vec_t                 d1_nxt, d2_nxt, r_nxt;
  lpdt_pkg::vec_t                 d1_r, d2_r, r_r;
  logic [lpdt_pkg::RSUM_W-1:0]    rad_r;
  logic                           v1_r;

  for (genvar k = 0; k < 3; k++) begin : g_diff
    logic signed [lpdt_pkg::COORD_W-1:0] s1, e1, s2, e2;
    assign s1 = in_chan.first_start[k*lpdt_pkg::COORD_W +: lpdt_pkg::COORD_W];
    assign e1 = in_chan.first_end[k*lpdt_pkg::COORD_W +: lpdt_pkg::COORD_W];
    assign s2 = in_chan.second_start[k*lpdt_pkg::COORD_W +: lpdt_pkg::COORD_W];
    assign e2 = in_chan.second_end[k*lpdt_pkg::COORD_W +: lpdt_pkg::COORD_W];
    assign d1_nxt[k] = lpdt_pkg::DIFF_W'(e1) - lpdt_pkg::DIFF_W'(s1);
    assign d2_nxt[k] = lpdt_pkg::DIFF_W'(e2) - lpdt_pkg::DIFF_W'(s2);
    assign r_nxt[k]  = lpdt_pkg::DIFF_W'(s1) - lpdt_pkg::DIFF_W'(s2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
      r_r   <= r_nxt;
      rad_r <= lpdt_pkg::RSUM_W'(in_chan.first_radius) +
               lpdt_pkg::RSUM_W'(in_chan.second_radius);
    end
  end

  // stage 2: dot products
  logic signed [lpdt_pkg::DOT_W-1:0] a_nxt, b_nxt, c_nxt, e_nxt, f_nxt;
  logic signed [lpdt_pkg::DOT_W-1:0] a2_r, c2_r;
  lpdt_pkg::ctx_t                    ctx2_r;
  logic                              v2_r;

  always_comb begin
    logic signed [lpdt_pkg::SQ_W-1:0] pa, pb, pc, pe, pf;
    a_nxt = '0;
    b_nxt = '0;
    c_nxt = '0;
    e_nxt = '0;
    f_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      pa = $signed(d1_r[k]) * $signed(d1_r[k]);
      pb = $signed(d2_r[k]) * $signed(d1_r[k]);
      pc = $signed(r_r[k]) * $signed(d1_r[k]);
      pe = $signed(d2_r[k]) * $signed(d2_r[k]);
      pf = $signed(r_r[k]) * $signed(d2_r[k]);
      a_nxt = a_nxt + lpdt_pkg::DOT_W'(pa);
      b_nxt = b_nxt + lpdt_pkg::DOT_W'(pb);
      c_nxt = c_nxt + lpdt_pkg::DOT_W'(pc);
      e_nxt = e_nxt + lpdt_pkg::DOT_W'(pe);
      f_nxt = f_nxt + lpdt_pkg::DOT_W'(pf);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r         <= a_nxt;
      c2_r         <= c_nxt;
      ctx2_r.d1    <= d1_r;
      ctx2_r.d2    <= d2_r;
      ctx2_r.r     <= r_r;
      ctx2_r.b     <= b_nxt;
      ctx2_r.f     <= f_nxt;
      ctx2_r.e     <= e_nxt;
      ctx2_r.rsq   <= rad_r * rad_r;
      ctx2_r.degen <= 1'b0;
    end
  end

  // stage 3: products of the dot products
  logic signed [lpdt_pkg::PROD_W-1:0] ae_r, bb_r, fb_r, ce_r;
  lpdt_pkg::ctx_t                     ctx3_r;
  logic                               v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ae_r   <= a2_r * $signed(ctx2_r.e);
      bb_r   <= $signed(ctx2_r.b) * $signed(ctx2_r.b);
      fb_r   <= $signed(ctx2_r.f) * $signed(ctx2_r.b);
      ce_r   <= c2_r * $signed(ctx2_r.e);
      ctx3_r <= ctx2_r;
    end
  end

  // stage 4: denominator and numerator
  logic signed [lpdt_pkg::PROD_W-1:0] den_r, num_r;
  lpdt_pkg::ctx_t                     ctx4_nxt;
  lpdt_pkg::ctx_t                     ctx4_r;
  logic                               v4_r;

  always_comb begin
    ctx4_nxt       = ctx3_r;
    ctx4_nxt.degen = (ae_r == bb_r) || (ctx3_r.e == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= ae_r - bb_r;
      num_r  <= fb_r - ce_r;
      ctx4_r <= ctx4_nxt;
    end
  end

  // stage 5: first divider set-up
  logic [lpdt_pkg::PROD_W-1:0]  dmag, nmag;
  logic [RW1-1:0]               n1_ext;
  logic [RW1-1:0]               n5_r;
  logic [lpdt_pkg::DIV1_DW-1:0] d5_r;
  lpdt_pkg::d1tag_t             tag5_r;
  logic                         v5_r;

  assign dmag   = den_r[lpdt_pkg::PROD_W-1] ? -den_r : den_r;
  assign nmag   = num_r[lpdt_pkg::PROD_W-1] ? -num_r : num_r;
  assign n1_ext = RW1'(nmag) << lpdt_pkg::T_FRAC;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n5_r       <= n1_ext;
      d5_r       <= dmag;
      tag5_r.ctx <= ctx4_r;
      tag5_r.neg <= den_r[lpdt_pkg::PROD_W-1] ^ num_r[lpdt_pkg::PROD_W-1];
      tag5_r.ovf <= n1_ext >= {dmag, lpdt_pkg::QB'(0)};
    end
  end

  logic                     v6;
  logic [lpdt_pkg::QB-1:0]  q1;
  lpdt_pkg::d1tag_t         tag6;

  lpdt_div #(
    .DW (lpdt_pkg::DIV1_DW),
    .QB (lpdt_pkg::QB),
    .TW ($bits(lpdt_pkg::d1tag_t))
  ) u_div_t1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_num    (n5_r),
    .in_den    (d5_r),
    .in_tag    (tag5_r),
    .out_valid (v6),
    .out_quo   (q1),
    .out_tag   (tag6)
  );

  // stage 7: saturate t1
  logic [lpdt_pkg::T_W-1:0] t1_7_r;
  lpdt_pkg::ctx_t           ctx7_r;
  logic                     v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_7_r <= lpdt_pkg::clamp_t(tag6.neg, tag6.ovf, q1);
      ctx7_r <= tag6.ctx;
    end
  end

  // stage 8: t1 * b
  logic signed [lpdt_pkg::TB_W-1:0] tb_r;
  logic [lpdt_pkg::T_W-1:0]         t1_8_r;
  lpdt_pkg::ctx_t                   ctx8_r;
  logic                             v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tb_r   <= $signed(t1_7_r) * $signed(ctx7_r.b);
      t1_8_r <= t1_7_r;
      ctx8_r <= ctx7_r;
    end
  end

  // stage 9: second numerator
  logic signed [lpdt_pkg::NUM2_W-1:0] num2_r;
  logic [lpdt_pkg::T_W-1:0]           t1_9_r;
  lpdt_pkg::ctx_t                     ctx9_r;
  logic                               v9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r <= (lpdt_pkg::NUM2_W'($signed(ctx8_r.f)) <<< lpdt_pkg::T_FRAC) +
                lpdt_pkg::NUM2_W'(tb_r);
      t1_9_r <= t1_8_r;
      ctx9_r <= ctx8_r;
    end
  end

  // stage 10: second divider set-up
  logic [lpdt_pkg::NUM2_W-1:0]  mag2;
  logic [RW2-1:0]               n2_ext;
  logic [RW2-1:0]               n10_r;
  logic [lpdt_pkg::DIV2_DW-1:0] d10_r;
  lpdt_pkg::d2tag_t             tag10_r;
  logic                         v10_r;

  assign mag2   = num2_r[lpdt_pkg::NUM2_W-1] ? -num2_r : num2_r;
  assign n2_ext = RW2'(mag2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n10_r       <= n2_ext;
      d10_r       <= ctx9_r.e;
      tag10_r.ctx <= ctx9_r;
      tag10_r.t1  <= t1_9_r;
      tag10_r.neg <= num2_r[lpdt_pkg::NUM2_W-1];
      tag10_r.ovf <= n2_ext >= {ctx9_r.e, lpdt_pkg::QB'(0)};
    end
  end

  logic                     v11;
  logic [lpdt_pkg::QB-1:0]  q2;
  lpdt_pkg::d2tag_t         tag11;

  lpdt_div #(
    .DW (lpdt_pkg::DIV2_DW),
    .QB (lpdt_pkg::QB),
    .TW ($bits(lpdt_pkg::d2tag_t))
  ) u_div_t2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v10_r),
    .in_num    (n10_r),
    .in_den    (d10_r),
    .in_tag    (tag10_r),
    .out_valid (v11),
    .out_quo   (q2),
    .out_tag   (tag11)
  );

  // stage 12: saturate t2
  logic [lpdt_pkg::T_W-1:0] t1_12_r, t2_12_r;
  lpdt_pkg::ctx_t           ctx12_r;
  logic                     v12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
    end else if (en) begin
      v12_r <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_12_r <= lpdt_pkg::clamp_t(tag11.neg, tag11.ovf, q2);
      t1_12_r <= tag11.t1;
      ctx12_r <= tag11.ctx;
    end
  end

  // stage 13..17: per-axis distance, stage 18: sum over the axes
  logic signed [lpdt_pkg::P_W-1:0] p1_r [3];
  logic signed [lpdt_pkg::P_W-1:0] p2_r [3];
  logic signed [lpdt_pkg::W_W-1:0] w_r [3];
  logic [lpdt_pkg::WMAG_W-1:0]     wmag_r [3];
  logic [2*lpdt_pkg::WHI_W-1:0]    hh_r [3];
  logic [lpdt_pkg::WHI_W+lpdt_pkg::WLO_W-1:0] hl_r [3];
  logic [2*lpdt_pkg::WLO_W-1:0]    ll_r [3];
  logic [lpdt_pkg::DIST_W-1:0]     lane_r [3];
  lpdt_pkg::vec_t                  r13_r;
  logic [lpdt_pkg::RSQ_W-1:0]      rsq13_r, rsq14_r, rsq15_r, rsq16_r, rsq17_r, rsq18_r;
  logic                            dg13_r, dg14_r, dg15_r, dg16_r, dg17_r, dg18_r;
  logic                            v13_r, v14_r, v15_r, v16_r, v17_r, v18_r;
  logic [lpdt_pkg::DIST_W-1:0]     dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v13_r <= 1'b0;
      v14_r <= 1'b0;
      v15_r <= 1'b0;
      v16_r <= 1'b0;
      v17_r <= 1'b0;
      v18_r <= 1'b0;
    end else if (en) begin
      v13_r <= v12_r;
      v14_r <= v13_r;
      v15_r <= v14_r;
      v16_r <= v15_r;
      v17_r <= v16_r;
      v18_r <= v17_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [lpdt_pkg::W_W-1:0] rs;
    assign rs = lpdt_pkg::W_W'($signed(r13_r[k])) <<< lpdt_pkg::T_FRAC;

    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[k]   <= $signed(t1_12_r) * $signed(ctx12_r.d1[k]);
        p2_r[k]   <= $signed(t2_12_r) * $signed(ctx12_r.d2[k]);
        w_r[k]    <= rs + lpdt_pkg::W_W'(p1_r[k]) - lpdt_pkg::W_W'(p2_r[k]);
        wmag_r[k] <= lpdt_pkg::WMAG_W'(w_r[k][lpdt_pkg::W_W-1] ? -w_r[k] : w_r[k]);
        hh_r[k]   <= wmag_r[k][lpdt_pkg::WMAG_W-1:lpdt_pkg::WLO_W] *
                     wmag_r[k][lpdt_pkg::WMAG_W-1:lpdt_pkg::WLO_W];
        hl_r[k]   <= wmag_r[k][lpdt_pkg::WMAG_W-1:lpdt_pkg::WLO_W] *
                     wmag_r[k][lpdt_pkg::WLO_W-1:0];
        ll_r[k]   <= wmag_r[k][lpdt_pkg::WLO_W-1:0] * wmag_r[k][lpdt_pkg::WLO_W-1:0];
        lane_r[k] <= (lpdt_pkg::DIST_W'(hh_r[k]) << (2 * lpdt_pkg::WLO_W)) +
                     (lpdt_pkg::DIST_W'(hl_r[k]) << (lpdt_pkg::WLO_W + 1)) +
                     lpdt_pkg::DIST_W'(ll_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r13_r   <= ctx12_r.r;
      rsq13_r <= ctx12_r.rsq;
      rsq14_r <= rsq13_r;
      rsq15_r <= rsq14_r;
      rsq16_r <= rsq15_r;
      rsq17_r <= rsq16_r;
      rsq18_r <= rsq17_r;
      dg13_r  <= ctx12_r.degen;
      dg14_r  <= dg13_r;
      dg15_r  <= dg14_r;
      dg16_r  <= dg15_r;
      dg17_r  <= dg16_r;
      dg18_r  <= dg17_r;
      dist_r  <= lane_r[0] + lane_r[1] + lane_r[2];
    end
  end

  // stage 19: output word
  logic [lpdt_pkg::DQ_W-1:0] dq;
  logic                      dq_sat;
  logic                      coll_r, deg_r;
  logic [lpdt_pkg::DQ_W-1:0] dq_r;

  assign dq_sat = |dist_r[lpdt_pkg::DIST_W-1:lpdt_pkg::DQ_SHIFT+lpdt_pkg::DQ_W];
  assign dq     = dq_sat ? {lpdt_pkg::DQ_W{1'b1}} :
                  dist_r[lpdt_pkg::DQ_SHIFT+lpdt_pkg::DQ_W-1:lpdt_pkg::DQ_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v18_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r  <= dg18_r;
      dq_r   <= dg18_r ? '0 : dq;
      coll_r <= !dg18_r && (dq < lpdt_pkg::DQ_W'(rsq18_r));
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.collided     = coll_r;
  assign out_chan.dist_squared = dq_r;
  assign out_chan.degenerate   = deg_r;

endmodule

`default_nettype wire
